FILE: src/aps_pkg.sv
package aps_pkg;

  // Field and register widths
  localparam int unsigned SampleRateW = 18;
  localparam int unsigned PacketRateW = 16;
  localparam int unsigned BytesPerFrameW = 7;
  localparam int unsigned FillW = 16;
  localparam int unsigned CountW = 7;
  localparam int unsigned FramesW = 8;
  localparam int unsigned BytesW = 14;
  localparam int unsigned ActionW = 2;
  localparam int unsigned BurstFramesW = 14;
  localparam int unsigned BurstBytesW = 20;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 18;

  // Packing of the stream data words
  localparam int unsigned SDataW = 24;
  localparam int unsigned MDataW = 64;

  // Accumulator: kept remainder plus sample rate
  localparam int unsigned RemW = PacketRateW;
  localparam int unsigned AccW = SampleRateW + 1;
  localparam int unsigned DivCntW = $clog2(AccW + 1);

  // Burst length bound
  localparam int unsigned MaxPackets = 32;
  localparam int unsigned LeftW = $clog2(MaxPackets + 1);

  // Saturation limits
  localparam logic [FramesW-1:0] FramesMax = '1;
  localparam logic [BytesW-1:0] BytesMax = '1;
  localparam logic [FramesW-1:0] SlowdownMinFrames = 8'd2;

  // Register reset values
  localparam logic [SampleRateW-1:0] SampleRateRst = 18'd44100;
  localparam logic [PacketRateW-1:0] PacketRateRst = 16'd8000;
  localparam logic [BytesPerFrameW-1:0] BytesPerFrameRst = 7'd12;
  localparam logic [FillW-1:0] TargetFillRst = 16'd4410;
  localparam logic [FillW-1:0] DeadZoneRst = 16'd220;
  localparam logic [FillW-1:0] LowGuardRst = 16'd176;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SAMPLE_RATE     = 3'd0,
    CFG_PACKET_RATE     = 3'd1,
    CFG_BYTES_PER_FRAME = 3'd2,
    CFG_TARGET_FILL     = 3'd3,
    CFG_DEAD_ZONE       = 3'd4,
    CFG_LOW_GUARD       = 3'd5
  } cfg_idx_e;

  // Drift actions reported on the last item
  typedef enum logic [ActionW-1:0] {
    ACT_NONE   = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_REMOVE = 2'd2
  } drift_action_e;

  typedef struct packed {
    logic [SampleRateW-1:0]    sample_rate;
    logic [PacketRateW-1:0]    packet_rate;
    logic [BytesPerFrameW-1:0] bytes_per_frame;
    logic [FillW-1:0]          fill_goal;
    logic [FillW-1:0]          dead_zone;
    logic [FillW-1:0]          low_guard;
  } cfg_t;

  typedef struct packed {
    logic             done;
    logic [AccW-1:0]  quot;
    logic [RemW-1:0]  rem;
  } div_res_t;

endpackage

FILE: src/audio_packet_size_scheduler.sv
// Audio packet size scheduler. Each input item asks for one burst of
// isochronous packets and yields one output item per packet, in order; the
// last one carries tlast, the drift action and the burst totals. Frames per
// packet come from a kept fractional remainder plus sample_rate, divided by
// packet_rate (zero is taken as one) in a shared restoring divider that
// produces one quotient bit per cycle. Each packet goes through start, 19
// divider steps, sizing and an output load that waits while the output
// side stalls; the input is not ready while a burst is in progress. A
// packet_count of zero yields nothing and a count above 32 is cut to 32.
// The user must write registers through the cfg port only while the block
// is idle; the block itself does not enforce it.
module audio_packet_size_scheduler (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration writes
  input  logic                             cfg_we_i,
  input  logic [aps_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [aps_pkg::CfgDataW-1:0]     cfg_data_i,
  // Burst requests
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [6:0] packet_count, [22:7] fill_level, [23] zero
  input  logic [aps_pkg::SDataW-1:0]       s_axis_tdata,
  // Packet sizes
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] packet_frames, [21:8] packet_bytes, [23:22] drift_action,
  // [37:24] burst_frames, [57:38] burst_bytes, [63:58] zero
  output logic [aps_pkg::MDataW-1:0]       m_axis_tdata,
  output logic                             m_axis_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_EMIT
  } state_e;

  localparam int unsigned ProdW = aps_pkg::FramesW + aps_pkg::BytesPerFrameW;

  aps_pkg::cfg_t     cfg;
  aps_pkg::div_res_t div_res;

  state_e                               state_q;
  logic [aps_pkg::RemW-1:0]             rem_q;
  logic [aps_pkg::LeftW-1:0]            left_q;
  logic [aps_pkg::PacketRateW-1:0]      divisor_q;
  logic                                 want_up_q;
  logic                                 want_down_q;
  logic [aps_pkg::FramesW-1:0]          frames_q;
  logic [aps_pkg::BurstFramesW-1:0]     sum_frames_q;
  logic [aps_pkg::BurstBytesW-1:0]      sum_bytes_q;
  logic                                 out_valid_q;
  logic [aps_pkg::MDataW-1:0]           out_data_q;
  logic                                 out_last_q;

  logic [aps_pkg::CountW-1:0]           in_count;
  logic [aps_pkg::FillW-1:0]            in_fill;
  logic [aps_pkg::FillW:0]              upper_bound;
  logic [aps_pkg::FillW:0]              fill_plus_dz;
  logic                                 want_up;
  logic                                 want_down;
  logic [aps_pkg::LeftW-1:0]            count_sat;
  logic [aps_pkg::AccW-1:0]             acc;
  logic                                 div_start;
  logic                                 is_last;
  logic [aps_pkg::FramesW-1:0]          frames_adj;
  logic [aps_pkg::ActionW-1:0]          action;
  logic [ProdW-1:0]                     prod;
  logic [aps_pkg::BytesW-1:0]           bytes;
  logic [aps_pkg::BurstFramesW-1:0]     sum_frames_next;
  logic [aps_pkg::BurstBytesW-1:0]      sum_bytes_next;
  logic                                 out_free;
  logic [aps_pkg::MDataW-1:0]           out_data_next;

  aps_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  aps_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc),
    .divisor_i  (divisor_q),
    .res_o      (div_res)
  );

  // Unpack the request and decide the drift direction up front
  always_comb begin
    in_count     = s_axis_tdata[aps_pkg::CountW-1:0];
    in_fill      = s_axis_tdata[aps_pkg::CountW +: aps_pkg::FillW];
    upper_bound  = {1'b0, cfg.fill_goal} + {1'b0, cfg.dead_zone};
    fill_plus_dz = {1'b0, in_fill} + {1'b0, cfg.dead_zone};
    want_up      = ({1'b0, in_fill} > upper_bound);
    want_down    = !want_up && (fill_plus_dz < {1'b0, cfg.fill_goal}) &&
                   (in_fill > cfg.low_guard);
    if (in_count > aps_pkg::CountW'(aps_pkg::MaxPackets)) begin
      count_sat = aps_pkg::LeftW'(aps_pkg::MaxPackets);
    end else begin
      count_sat = in_count[aps_pkg::LeftW-1:0];
    end
  end

  // Feed the divider with remainder plus sample rate
  assign acc       = aps_pkg::AccW'(rem_q) + aps_pkg::AccW'(cfg.sample_rate);
  assign div_start = (state_q == ST_START);

  // Size the packet: drift adjust on the last one, then bytes and totals
  always_comb begin
    is_last    = (left_q == aps_pkg::LeftW'(1));
    frames_adj = frames_q;
    action     = aps_pkg::ACT_NONE;
    if (is_last) begin
      if (want_up_q && (frames_q < aps_pkg::FramesMax)) begin
        frames_adj = frames_q + 1'b1;
        action     = aps_pkg::ACT_ADD;
      end else if (want_down_q && (frames_q > aps_pkg::SlowdownMinFrames)) begin
        frames_adj = frames_q - 1'b1;
        action     = aps_pkg::ACT_REMOVE;
      end
    end
    prod  = ProdW'(frames_adj) * ProdW'(cfg.bytes_per_frame);
    bytes = (prod > ProdW'(aps_pkg::BytesMax)) ? aps_pkg::BytesMax
                                               : prod[aps_pkg::BytesW-1:0];
    sum_frames_next = sum_frames_q + aps_pkg::BurstFramesW'(frames_adj);
    sum_bytes_next  = sum_bytes_q + aps_pkg::BurstBytesW'(bytes);
    out_data_next   = '0;
    out_data_next[7:0]   = frames_adj;
    out_data_next[21:8]  = bytes;
    if (is_last) begin
      out_data_next[23:22] = action;
      out_data_next[37:24] = sum_frames_next;
      out_data_next[57:38] = sum_bytes_next;
    end
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rem_q        <= '0;
      left_q       <= '0;
      divisor_q    <= '0;
      want_up_q    <= 1'b0;
      want_down_q  <= 1'b0;
      frames_q     <= '0;
      sum_frames_q <= '0;
      sum_bytes_q  <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if ((state_q == ST_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid && (in_count != '0)) begin
            left_q       <= count_sat;
            divisor_q    <= (cfg.packet_rate == '0) ? aps_pkg::PacketRateW'(1)
                                                    : cfg.packet_rate;
            want_up_q    <= want_up;
            want_down_q  <= want_down;
            sum_frames_q <= '0;
            sum_bytes_q  <= '0;
            state_q      <= ST_START;
          end
        end
        ST_START: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_res.done) begin
            rem_q    <= div_res.rem;
            frames_q <= (div_res.quot > aps_pkg::AccW'(aps_pkg::FramesMax))
                        ? aps_pkg::FramesMax : div_res.quot[aps_pkg::FramesW-1:0];
            state_q  <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_data_q   <= out_data_next;
            out_last_q   <= is_last;
            sum_frames_q <= sum_frames_next;
            sum_bytes_q  <= sum_bytes_next;
            left_q       <= left_q - 1'b1;
            state_q      <= is_last ? ST_IDLE : ST_START;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: src/aps_cfg_regs.sv
module aps_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [aps_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [aps_pkg::CfgDataW-1:0]    cfg_data_i,
  output aps_pkg::cfg_t                   cfg_o
);

  aps_pkg::cfg_t cfg_q;

  // Write one register per enabled cycle, ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_rate     <= aps_pkg::SampleRateRst;
      cfg_q.packet_rate     <= aps_pkg::PacketRateRst;
      cfg_q.bytes_per_frame <= aps_pkg::BytesPerFrameRst;
      cfg_q.fill_goal       <= aps_pkg::TargetFillRst;
      cfg_q.dead_zone       <= aps_pkg::DeadZoneRst;
      cfg_q.low_guard       <= aps_pkg::LowGuardRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aps_pkg::CFG_SAMPLE_RATE: begin
          cfg_q.sample_rate <= cfg_data_i[aps_pkg::SampleRateW-1:0];
        end
        aps_pkg::CFG_PACKET_RATE: begin
          cfg_q.packet_rate <= cfg_data_i[aps_pkg::PacketRateW-1:0];
        end
        aps_pkg::CFG_BYTES_PER_FRAME: begin
          cfg_q.bytes_per_frame <= cfg_data_i[aps_pkg::BytesPerFrameW-1:0];
        end
        aps_pkg::CFG_TARGET_FILL: begin
          cfg_q.fill_goal <= cfg_data_i[aps_pkg::FillW-1:0];
        end
        aps_pkg::CFG_DEAD_ZONE: begin
          cfg_q.dead_zone <= cfg_data_i[aps_pkg::FillW-1:0];
        end
        aps_pkg::CFG_LOW_GUARD: begin
          cfg_q.low_guard <= cfg_data_i[aps_pkg::FillW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/aps_divider.sv
module aps_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [aps_pkg::AccW-1:0]      dividend_i,
  input  logic [aps_pkg::RemW-1:0]      divisor_i,
  output aps_pkg::div_res_t             res_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [aps_pkg::DivCntW-1:0]   cnt_q;
  logic [aps_pkg::AccW-1:0]      num_q;
  logic [aps_pkg::AccW-1:0]      quo_q;
  logic [aps_pkg::RemW-1:0]      rem_q;
  logic [aps_pkg::RemW-1:0]      div_q;

  logic [aps_pkg::RemW:0]        trial;
  logic [aps_pkg::RemW:0]        diff;
  logic                          fits;

  // One restoring step: bring down the next dividend bit and try the subtract
  always_comb begin
    trial = {rem_q, num_q[aps_pkg::AccW-1]};
    diff  = trial - {1'b0, div_q};
    fits  = (trial >= {1'b0, div_q});
  end

  // Latch operands on start, then one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == aps_pkg::DivCntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= aps_pkg::DivCntW'(aps_pkg::AccW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == aps_pkg::DivCntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      quo_q <= '0;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= {num_q[aps_pkg::AccW-2:0], 1'b0};
      quo_q <= {quo_q[aps_pkg::AccW-2:0], fits};
      rem_q <= fits ? diff[aps_pkg::RemW-1:0] : trial[aps_pkg::RemW-1:0];
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = quo_q;
  assign res_o.rem  = rem_q;

endmodule

FILE: tb/tb_audio_packet_size_scheduler.sv
`timescale 1ns / 100ps

module tb_audio_packet_size_scheduler;
  import aps_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned IdleSettle = 60;

  // One expected packet size item
  typedef struct {
    logic [FramesW-1:0]      frames;
    logic [BytesW-1:0]       nbytes;
    drift_action_e           action;
    logic [BurstFramesW-1:0] burst_frames;
    logic [BurstBytesW-1:0]  burst_bytes;
    logic                    is_last;
  } pkt_size_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  cfg_idx_e             cfg_idx_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [SDataW-1:0]    s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [MDataW-1:0]    m_axis_tdata;
  logic                 m_axis_tlast;

  // Sizer state as the scheduler should hold it
  cfg_t                 cfg_shadow;
  logic [RemW-1:0]      rate_rem_shadow;
  pkt_size_t            expected_sizes[$];
  pkt_size_t            size_due;

  int unsigned          mismatch_count;
  int unsigned          cycle_count;
  int unsigned          n_requests;
  int unsigned          n_pkt_items;
  int unsigned          n_added;
  int unsigned          n_removed;
  int unsigned          n_settings;

  audio_packet_size_scheduler u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Compute the packet sizes of one burst and queue them
  function automatic void predict_burst(logic [CountW-1:0] count, logic [FillW-1:0] fill);
    int unsigned n, divisor, acc, quot, nb, tot_f, tot_b;
    int unsigned fl, tgt, dz, lg, bpf;
    int unsigned fr[64];
    drift_action_e act;
    pkt_size_t ps;
    n = count;
    if (n == 0) return;
    if (n > MaxPackets) n = MaxPackets;
    divisor = (cfg_shadow.packet_rate == 0) ? 1 : cfg_shadow.packet_rate;
    fl = fill;
    tgt = cfg_shadow.fill_goal;
    dz = cfg_shadow.dead_zone;
    lg = cfg_shadow.low_guard;
    bpf = cfg_shadow.bytes_per_frame;
    act = ACT_NONE;
    tot_f = 0;
    tot_b = 0;
    for (int i = 0; i < n; i++) begin
      acc = rate_rem_shadow + cfg_shadow.sample_rate;
      quot = acc / divisor;
      rate_rem_shadow = RemW'(acc % divisor);
      fr[i] = (quot > FramesMax) ? FramesMax : quot;
    end
    // Drift compensation lands on the last packet only
    if (fl > tgt + dz) begin
      if (fr[n-1] < FramesMax) begin
        fr[n-1]++;
        act = ACT_ADD;
      end
    end else if (fl + dz < tgt && fl > lg) begin
      if (fr[n-1] > SlowdownMinFrames) begin
        fr[n-1]--;
        act = ACT_REMOVE;
      end
    end
    for (int i = 0; i < n; i++) begin
      nb = fr[i] * bpf;
      if (nb > BytesMax) nb = BytesMax;
      tot_f += fr[i];
      tot_b += nb;
      ps.is_last = (i == n - 1);
      ps.frames = FramesW'(fr[i]);
      ps.nbytes = BytesW'(nb);
      ps.action = ps.is_last ? act : ACT_NONE;
      ps.burst_frames = ps.is_last ? BurstFramesW'(tot_f) : '0;
      ps.burst_bytes = ps.is_last ? BurstBytesW'(tot_b) : '0;
      expected_sizes.push_back(ps);
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare each accepted packet item with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_sizes.size() == 0) begin
        $display("%0t: unexpected packet item, expected none actual tdata=%h tlast=%b",
                 $time, m_axis_tdata, m_axis_tlast);
        mismatch_count++;
      end else begin
        size_due = expected_sizes.pop_front();
        n_pkt_items++;
        check_field("packet_frames", size_due.frames, m_axis_tdata[7:0]);
        check_field("packet_bytes", size_due.nbytes, m_axis_tdata[21:8]);
        check_field("drift_action", size_due.action, m_axis_tdata[23:22]);
        check_field("burst_frames", size_due.burst_frames, m_axis_tdata[37:24]);
        check_field("burst_bytes", size_due.burst_bytes, m_axis_tdata[57:38]);
        check_field("tlast", size_due.is_last, m_axis_tlast);
        if (size_due.is_last && size_due.action == ACT_ADD) n_added++;
        if (size_due.is_last && size_due.action == ACT_REMOVE) n_removed++;
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout, %0d packet items still due", $time, expected_sizes.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: switch between always ready, random ready and alternating ready and stall runs
  initial begin
    int unsigned mode, mode_left, run_left;
    m_axis_tready = 1'b0;
    mode = 0;
    mode_left = 0;
    run_left = 0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= $urandom_range(0, 1);
        default: begin
          if (run_left == 0) begin
            m_axis_tready <= ~m_axis_tready;
            run_left = m_axis_tready ? $urandom_range(1, 8) : $urandom_range(1, 6);
          end else begin
            run_left--;
          end
        end
      endcase
    end
  end

  // Offer one burst request; keep tvalid high if another item follows at once
  task automatic send_req(logic [CountW-1:0] count, logic [FillW-1:0] fill, bit hold_valid);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, fill, count};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_burst(count, fill);
    n_requests++;
    @(negedge clk_i);
    if (!hold_valid) s_axis_tvalid <= 1'b0;
  endtask

  // Hold off until every due packet has come out
  task automatic drain_sizes();
    do @(negedge clk_i); while (expected_sizes.size() != 0);
  endtask

  task automatic wait_idle();
    drain_sizes();
    repeat (IdleSettle) @(negedge clk_i);
  endtask

  task automatic drive_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    case (idx)
      CFG_SAMPLE_RATE:     cfg_shadow.sample_rate = val;
      CFG_PACKET_RATE:     cfg_shadow.packet_rate = val[PacketRateW-1:0];
      CFG_BYTES_PER_FRAME: cfg_shadow.bytes_per_frame = val[BytesPerFrameW-1:0];
      CFG_TARGET_FILL:     cfg_shadow.fill_goal = val[FillW-1:0];
      CFG_DEAD_ZONE:       cfg_shadow.dead_zone = val[FillW-1:0];
      CFG_LOW_GUARD:       cfg_shadow.low_guard = val[FillW-1:0];
      default: ;
    endcase
  endtask

  // Write all six registers back to back once the block is idle
  task automatic apply_settings(int unsigned sr, int unsigned pr, int unsigned bpf,
                                int unsigned tgt, int unsigned dz, int unsigned lg);
    wait_idle();
    drive_reg(CFG_SAMPLE_RATE, CfgDataW'(sr));
    drive_reg(CFG_PACKET_RATE, CfgDataW'(pr));
    drive_reg(CFG_BYTES_PER_FRAME, CfgDataW'(bpf));
    drive_reg(CFG_TARGET_FILL, CfgDataW'(tgt));
    drive_reg(CFG_DEAD_ZONE, CfgDataW'(dz));
    drive_reg(CFG_LOW_GUARD, CfgDataW'(lg));
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [CountW-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 70) return CountW'($urandom_range(1, 8));
    if (r < 88) return CountW'($urandom_range(9, 32));
    return CountW'($urandom_range(33, 127));
  endfunction

  // Fill levels cluster around the drift thresholds
  function automatic logic [FillW-1:0] pick_fill();
    int f, tgt, dz, lg;
    tgt = cfg_shadow.fill_goal;
    dz = cfg_shadow.dead_zone;
    lg = cfg_shadow.low_guard;
    case ($urandom_range(0, 3))
      0: f = $urandom_range(0, 65535);
      1, 2: f = tgt + int'($urandom_range(0, 2 * dz + 8)) - dz - 4;
      default: f = lg + int'($urandom_range(0, 4)) - 2;
    endcase
    if (f < 0) f = 0;
    if (f > 65535) f = 65535;
    return FillW'(f);
  endfunction

  // Random requests in bursts, with gaps of varied length between bursts
  task automatic send_random_items(int unsigned total);
    int unsigned burst_left, gap;
    logic [CountW-1:0] count;
    logic [FillW-1:0] fill;
    burst_left = 0;
    for (int k = 0; k < total; k++) begin
      if (burst_left == 0) burst_left = $urandom_range(1, 8);
      burst_left--;
      count = pick_count();
      fill = pick_fill();
      if (burst_left != 0 || k == total - 1) gap = 0;
      else if ($urandom_range(0, 3) == 0) gap = $urandom_range(20, 400);
      else gap = $urandom_range(1, 12);
      send_req(count, fill, gap == 0 && k != total - 1);
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Reset settings: threshold edges, empty and oversized bursts
  task automatic test_reset_config();
    send_req(7'd1, 16'd4410, 1'b1);
    send_req(7'd0, 16'd65535, 1'b1);
    send_req(7'd32, 16'd4631, 1'b1);
    send_req(7'd33, 16'd4630, 1'b1);
    send_req(7'd127, 16'd4189, 1'b1);
    send_req(7'd64, 16'd4190, 1'b1);
    send_req(7'd2, 16'd177, 1'b1);
    send_req(7'd3, 16'd176, 1'b1);
    send_req(7'd5, 16'd0, 1'b1);
    send_req(7'd4, 16'd65535, 1'b0);
  endtask

  // Zero divisor, saturated frames and bytes, full packet, stale remainder
  task automatic test_config_extremes();
    apply_settings(192000, 0, 127, 65535, 0, 0);
    send_req(7'd2, 16'd65535, 1'b1);
    send_req(7'd3, 16'd1, 1'b0);
    apply_settings(262143, 0, 0, 0, 0, 65535);
    send_req(7'd1, 16'd1, 1'b0);
    apply_settings(65534, 65535, 12, 4410, 220, 176);
    send_req(7'd5, 16'd4410, 1'b0);
    apply_settings(8000, 1000, 12, 4410, 220, 176);
    send_req(7'd3, 16'd4410, 1'b0);
  endtask

  // Slow-down is skipped when the last packet holds two frames or fewer
  task automatic test_slowdown_floor();
    apply_settings(16000, 8000, 12, 4410, 220, 176);
    send_req(7'd2, 16'd1000, 1'b0);
    apply_settings(24000, 8000, 12, 4410, 220, 176);
    send_req(7'd1, 16'd1000, 1'b0);
  endtask

  task automatic test_random_traffic();
    int unsigned tgt;
    for (int phase = 0; phase < 5; phase++) begin
      tgt = $urandom_range(0, 65535);
      case (phase)
        0: apply_settings(8000, 1000, 1, 0, 0, 0);
        1: apply_settings(192000, 65535, 64, 65535, 65535, 65535);
        2: apply_settings($urandom_range(8000, 192000), $urandom_range(1000, 8000),
                          $urandom_range(1, 64), tgt, $urandom_range(0, 2000),
                          $urandom_range(0, tgt));
        default: apply_settings($urandom_range(8000, 192000), $urandom_range(1000, 65535),
                                $urandom_range(1, 64), tgt, $urandom_range(0, 2000),
                                $urandom_range(0, tgt));
      endcase
      send_random_items(42);
    end
  endtask

  // One request at a time, each drained before the next
  task automatic test_drain_pause();
    apply_settings(44100, 8000, 12, 4410, 220, 176);
    for (int k = 0; k < 8; k++) begin
      send_req(pick_count(), pick_fill(), 1'b0);
      drain_sizes();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_SAMPLE_RATE;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    mismatch_count = 0;
    cycle_count = 0;
    n_requests = 0;
    n_pkt_items = 0;
    n_added = 0;
    n_removed = 0;
    n_settings = 0;
    cfg_shadow.sample_rate = SampleRateRst;
    cfg_shadow.packet_rate = PacketRateRst;
    cfg_shadow.bytes_per_frame = BytesPerFrameRst;
    cfg_shadow.fill_goal = TargetFillRst;
    cfg_shadow.dead_zone = DeadZoneRst;
    cfg_shadow.low_guard = LowGuardRst;
    rate_rem_shadow = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_config();
    test_config_extremes();
    test_slowdown_floor();
    test_random_traffic();
    test_drain_pause();

    drain_sizes();
    repeat (IdleSettle) @(negedge clk_i);
    if (expected_sizes.size() != 0) begin
      $display("%0t: %0d packet items never arrived", $time, expected_sizes.size());
      mismatch_count += expected_sizes.size();
    end
    $display("Covered %0d burst requests, %0d packet items, %0d register settings.",
             n_requests, n_pkt_items, n_settings);
    $display("Drift added a frame on %0d bursts and removed one on %0d.", n_added, n_removed);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
